// ----- rtl/ssk_pkg.sv -----
// shared record type and field widths for the selection sort block
package ssk_pkg;

  localparam int KeyW = 16;
  localparam int TagW = 6;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } rec_t;

  // control that travels with each read data beat into the min scan
  typedef struct packed {
    logic vld;
    logic first;
    logic tail;
  } scan_ctl_t;

endpackage

// ----- rtl/ssk_if.sv -----
// handshake channel interfaces for loaded records and sorted results
interface ssk_in_if;
  logic                    valid;
  logic                    ready;
  logic [ssk_pkg::KeyW-1:0] room_capacity;
  logic [ssk_pkg::TagW-1:0] record_tag;
  logic                    last_item;

  modport source (output valid, output room_capacity, output record_tag,
                  output last_item, input ready);
  modport sink (input valid, input room_capacity, input record_tag,
                input last_item, output ready);
endinterface

interface ssk_out_if;
  logic                    valid;
  logic                    ready;
  logic [ssk_pkg::KeyW-1:0] sorted_capacity;
  logic [ssk_pkg::TagW-1:0] sorted_tag;
  logic                    last_result;

  modport source (output valid, output sorted_capacity, output sorted_tag,
                  output last_result, input ready);
  modport sink (input valid, input sorted_capacity, input sorted_tag,
                input last_result, output ready);
endinterface

// ----- rtl/selection_sort_by_key_top.sv -----
// top level: record loading, selection pass sequencing and result output
//
// channel  dir  beat                                         accepted when
// in_ch    in   room_capacity, record_tag, last_item         valid && ready
// out_ch   out  sorted_capacity, sorted_tag, last_result     valid && ready
//
// loading accepts one record per cycle; records past MAX_ITEMS are dropped.
// after the last record, result k of n (k from 0) takes one ram read per remaining entry,
// the registered ram read and one write-back.
// a pass waits at its write-back while the output register is still full.
// input is not ready while a set is being sorted and emitted.
// rst is synchronous; no clearing pass, only entries of the current set are read.
module selection_sort_by_key_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst,
  ssk_in_if.sink    in_ch,
  ssk_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int RW = $bits(ssk_pkg::rec_t);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [AW-1:0] lastidx;
  logic [AW-1:0] rd_ptr;
  logic          issue_done;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;

  logic          out_valid;
  ssk_pkg::rec_t out_rec;
  logic          out_last;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ssk_pkg::rec_t wr_rec;
  logic [RW-1:0] rd_word;
  ssk_pkg::rec_t rd_rec;

  ssk_pkg::scan_ctl_t scan_ctl;
  logic          scan_done;
  ssk_pkg::rec_t min_rec;
  logic [AW-1:0] pick;
  ssk_pkg::rec_t head;

  logic          in_fire;
  logic          full;
  logic          out_free;
  logic          out_load;
  logic          rd_en;

  assign in_ch.ready = (state == S_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (count == CW'(MAX_ITEMS));
  assign out_free    = !out_valid || out_ch.ready;
  assign out_load    = (state == S_PUT) && out_free;
  assign rd_en       = (state == S_SCAN) && !issue_done;
  assign rd_rec      = ssk_pkg::rec_t'(rd_word);

  assign out_ch.valid           = out_valid;
  assign out_ch.sorted_capacity = out_rec.key;
  assign out_ch.sorted_tag      = out_rec.tag;
  assign out_ch.last_result     = out_last;

  // shared write port: loading writes at the fill count, a pass writes back
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_rec.key = in_ch.room_capacity;
    wr_rec.tag = in_ch.record_tag;
    case (state)
      S_LOAD: begin
        wr_en = in_fire && !full;
      end
      S_PUT: begin
        // the displaced head record moves to where the minimum came from
        wr_en   = out_free;
        wr_addr = pick;
        wr_rec  = head;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  ssk_ram #(
    .Width (RW),
    .Depth (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (RW'(wr_rec)),
    .raddr (rd_ptr),
    .rdata (rd_word)
  );

  assign scan_ctl.vld   = rd_vld;
  assign scan_ctl.first = (rd_idx == pos);
  assign scan_ctl.tail  = (rd_idx == lastidx);

  ssk_minscan #(
    .AW (AW)
  ) u_minscan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .data    (rd_rec),
    .idx     (rd_idx),
    .done    (scan_done),
    .min_rec (min_rec),
    .pick    (pick),
    .head    (head)
  );

  always_ff @(posedge clk) begin
    rd_idx <= rd_ptr;
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      out_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      issue_done <= 1'b1;
    end else begin
      rd_vld <= rd_en;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (in_ch.last_item) begin
              lastidx    <= full ? AW'(MAX_ITEMS - 1) : count[AW-1:0];
              count      <= '0;
              pos        <= '0;
              rd_ptr     <= '0;
              issue_done <= 1'b0;
              state      <= S_SCAN;
            end else if (!full) begin
              count <= count + CW'(1);
            end
          end
        end
        S_SCAN: begin
          if (!issue_done) begin
            if (rd_ptr == lastidx) begin
              issue_done <= 1'b1;
            end else begin
              rd_ptr <= rd_ptr + AW'(1);
            end
          end
          if (scan_done) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_rec   <= min_rec;
            out_last  <= (pos == lastidx);
            if (pos == lastidx) begin
              state <= S_LOAD;
            end else begin
              pos        <= pos + AW'(1);
              rd_ptr     <= pos + AW'(1);
              issue_done <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ssk_ram.sv -----
// generic single-write single-read ram with registered read data
module ssk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ssk_minscan.sv -----
// running first-minimum search over the read beats of one selection pass
module ssk_minscan #(
  parameter int AW = 6
) (
  input  logic                clk,
  input  ssk_pkg::scan_ctl_t  ctl,
  input  ssk_pkg::rec_t       data,
  input  logic [AW-1:0]       idx,
  output logic                done,
  output ssk_pkg::rec_t       min_rec,
  output logic [AW-1:0]       pick,
  output ssk_pkg::rec_t       head
);

  assign done = ctl.vld && ctl.tail;

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      if (ctl.first) begin
        min_rec <= data;
        pick    <= idx;
        head    <= data;
      end else if (data.key < min_rec.key) begin
        // strict less-than keeps the first of equal keys
        min_rec <= data;
        pick    <= idx;
      end
    end
  end

endmodule

// ----- test/tb_selection_sort_by_key_top.sv -----
`timescale 1ns / 1ps
// testbench: record sets of many sizes and key spreads sorted and checked beat by beat
module tb_selection_sort_by_key_top;

  localparam int MaxItems = 64;
  localparam int KeyW = ssk_pkg::KeyW;
  localparam int TagW = ssk_pkg::TagW;

  typedef struct packed {
    ssk_pkg::rec_t rec;
    logic last;
  } sorted_beat_t;

  typedef enum int {
    KeysFull,
    KeysClustered,
    KeysMixed
  } key_spread_t;

  logic clk = 1'b0;
  logic rst;

  ssk_in_if in_ch();
  ssk_out_if out_ch();

  selection_sort_by_key_top #(.MAX_ITEMS(MaxItems)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned records_loaded = 0;
  int unsigned sets_closed = 0;
  int unsigned full_sets = 0;
  int unsigned results_seen = 0;

  // copy of the block's store for the set being loaded
  ssk_pkg::rec_t loaded_recs[MaxItems];
  int unsigned loaded_count = 0;
  sorted_beat_t sorted_beats[$];

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  // selection sort with strict less-than, first minimum wins, then queue the run
  function automatic void sort_loaded_set();
    int unsigned i;
    int unsigned j;
    int unsigned pick;
    ssk_pkg::rec_t held;
    sorted_beat_t beat;
    for (i = 0; i + 1 < loaded_count; i++) begin
      pick = i;
      for (j = i + 1; j < loaded_count; j++)
        if (loaded_recs[j].key < loaded_recs[pick].key) pick = j;
      held = loaded_recs[i];
      loaded_recs[i] = loaded_recs[pick];
      loaded_recs[pick] = held;
    end
    for (i = 0; i < loaded_count; i++) begin
      beat.rec = loaded_recs[i];
      beat.last = (i + 1 == loaded_count);
      sorted_beats.push_back(beat);
    end
    loaded_count = 0;
  endfunction

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      records_loaded++;
      if (loaded_count < MaxItems) begin
        loaded_recs[loaded_count].key = in_ch.room_capacity;
        loaded_recs[loaded_count].tag = in_ch.record_tag;
        loaded_count++;
      end else if (in_ch.last_item) begin
        full_sets++;
      end
      if (in_ch.last_item) begin
        sets_closed++;
        sort_loaded_set();
      end
    end
  end

  always @(posedge clk) begin
    sorted_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (sorted_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat key %h tag %h last %b",
                                  out_ch.sorted_capacity, out_ch.sorted_tag,
                                  out_ch.last_result));
      end else begin
        want = sorted_beats.pop_front();
        if (out_ch.sorted_capacity !== want.rec.key)
          report_mismatch($sformatf("key %h, wanted %h", out_ch.sorted_capacity,
                                    want.rec.key));
        if (out_ch.sorted_tag !== want.rec.tag)
          report_mismatch($sformatf("tag %h, wanted %h (key %h)", out_ch.sorted_tag,
                                    want.rec.tag, want.rec.key));
        if (out_ch.last_result !== want.last)
          report_mismatch($sformatf("last %b, wanted %b (key %h)", out_ch.last_result,
                                    want.last, want.rec.key));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // leaves valid high on return so the next record can follow back to back
  task automatic send_record(input logic [KeyW-1:0] key, input logic [TagW-1:0] tag,
                             input logic last);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.room_capacity <= key;
    in_ch.record_tag <= tag;
    in_ch.last_item <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  function automatic logic [KeyW-1:0] random_key(input key_spread_t spread);
    logic [KeyW-1:0] key;
    case (spread)
      KeysFull: key = KeyW'($urandom_range(16'hffff));
      KeysClustered: key = KeyW'($urandom_range(3));
      default: begin
        case ($urandom_range(3))
          0: key = '0;
          1: key = '1;
          2: key = KeyW'($urandom_range(7));
          default: key = KeyW'($urandom_range(16'hffff));
        endcase
      end
    endcase
    return key;
  endfunction

  task automatic send_set(input int unsigned n, input key_spread_t spread);
    int unsigned k;
    for (k = 0; k < n; k++)
      send_record(random_key(spread), TagW'($urandom_range(63)), k + 1 == n);
  endtask

  // mostly small sets, a few near or past the store depth
  function automatic int unsigned pick_set_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 32);
    if (r < 98) return $urandom_range(33, MaxItems);
    return $urandom_range(MaxItems + 1, MaxItems + 4);
  endfunction

  task automatic test_extremes_and_ties();
    // single-record sets at both ends of the key and tag
    send_record(16'h0000, 6'h00, 1'b1);
    send_record(16'hffff, 6'h3f, 1'b1);
    // reverse-ish order with extremes
    send_record(16'hffff, 6'h2a, 1'b0);
    send_record(16'h0000, 6'h15, 1'b0);
    send_record(16'h8000, 6'h01, 1'b0);
    send_record(16'h7fff, 6'h02, 1'b1);
    // equal keys reordered by the swaps
    send_record(16'h0007, 6'h10, 1'b0);
    send_record(16'h0007, 6'h11, 1'b0);
    send_record(16'h0003, 6'h12, 1'b0);
    send_record(16'h0007, 6'h13, 1'b1);
    // all keys equal
    send_record(16'h5555, 6'h14, 1'b0);
    send_record(16'h5555, 6'h15, 1'b0);
    send_record(16'h5555, 6'h16, 1'b1);
    // already ascending
    send_record(16'h0001, 6'h1e, 1'b0);
    send_record(16'h0002, 6'h1f, 1'b0);
    send_record(16'haaaa, 6'h20, 1'b1);
    send_record(16'h00ff, 6'h3f, 1'b0);
    send_record(16'hff00, 6'h00, 1'b1);
  endtask

  // exactly full, one over (last record dropped), several over
  task automatic test_store_full();
    send_set(MaxItems, KeysFull);
    send_set(MaxItems + 1, KeysMixed);
    send_set(MaxItems + 6, KeysClustered);
  endtask

  task automatic test_random_sets(input int unsigned idle, input int unsigned stall,
                                  input int unsigned target);
    int unsigned sent;
    int unsigned n;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < target) begin
      n = pick_set_size();
      send_set(n, key_spread_t'($urandom_range(2)));
      sent += n;
    end
  endtask

  task automatic test_drain();
    in_ch.valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    // let the last accepted record reach the predictor first
    @(posedge clk);
    while (sorted_beats.size() != 0) @(posedge clk);
    // room for a stray beat to show up
    repeat (4 * MaxItems) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.room_capacity <= '0;
    in_ch.record_tag <= '0;
    in_ch.last_item <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_extremes_and_ties();
    test_store_full();
    test_random_sets(0, 0, 55);
    test_random_sets(83, 0, 55);
    test_random_sets(0, 83, 55);
    test_random_sets(16, 16, 55);
    test_drain();

    $display("loaded %0d records in %0d sets (%0d past store depth), checked %0d beats",
             records_loaded, sets_closed, full_sets, results_seen);
    $display("idling phases: none, sender, receiver, both; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats outstanding", sorted_beats.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
